FILE: src/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// No dependencies; imported by every module of the block.
package bsa_pkg;

  localparam int SLOT_W    = 6;
  localparam int BSIZE_W   = 27;
  localparam int CNT_W     = 7;
  localparam int OFFS_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_STEPS = 32;
  localparam int DCNT_W    = 5;

  localparam logic [BSIZE_W-1:0] BSIZE_RST = BSIZE_W'(67108864);
  localparam logic [CNT_W-1:0]   COUNT_RST = CNT_W'(64);

  localparam logic [CFG_IDX_W-1:0] CFG_BUF_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL          = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_OFFSET    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [OFFS_W-1:0] offs;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [OFFS_W-1:0]   arena_offset;
  } res_t;

  typedef struct packed {
    logic               start;
    logic [OFFS_W-1:0]  dividend;
    logic [BSIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [OFFS_W-1:0]  quot;
    logic [BSIZE_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: src/bsa_front.sv
// Front end: accepts command words, decodes the operation and queues them.
// Depends on bsa_pkg.
module bsa_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_command,
  input  logic [31:0]          in_buffer_offset,
  output logic                 q_vld,
  output bsa_pkg::req_t        q_head,
  input  logic                 q_pop
);
  import bsa_pkg::*;

  req_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;
  req_t       req_in;

  assign full    = (cnt_r == 2'd2);
  assign q_vld   = (cnt_r != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_vld;

  always_comb begin
    req_in.op   = in_command ? OP_FREE : OP_ALLOC;
    req_in.offs = in_buffer_offset;
  end

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= req_in;
    end
  end

  assign q_head = mem_r[rd_ptr_r];

endmodule

FILE: src/bsa_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bsa_pkg.
module bsa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bsa_pkg::div_req_t req,
  output bsa_pkg::div_rsp_t rsp
);
  import bsa_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [DCNT_W-1:0]  cnt_r;
  logic [OFFS_W-1:0]  quo_r;
  logic [BSIZE_W-1:0] rem_r, rem_nxt;
  logic [BSIZE_W-1:0] dvs_r;
  logic [BSIZE_W:0]   trial;
  logic               qbit;

  always_comb begin
    trial = {rem_r, quo_r[OFFS_W-1]};
    qbit  = (trial >= {1'b0, dvs_r});
    if (qbit) begin
      rem_nxt = BSIZE_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[BSIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[OFFS_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: src/bsa_back.sv
// Back end: owns the allocation map and hint, runs next-fit search and free
// checks, and holds the result word. Depends on bsa_pkg and bsa_div.
module bsa_back #(
  parameter int MAX_SLOTS          = 64,
  parameter int CONTROL_AREA_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_vld,
  input  bsa_pkg::req_t               q_head,
  output logic                        q_pop,
  input  logic [bsa_pkg::BSIZE_W-1:0] buf_size,
  input  logic [bsa_pkg::CNT_W-1:0]   eff_n,
  output logic                        res_vld,
  output bsa_pkg::res_t               res,
  input  logic                        res_pop
);
  import bsa_pkg::*;

  localparam int IW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int MUL_W = IW + BSIZE_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOD    = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_CHECK  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [MAX_SLOTS-1:0] map_r, map_nxt;
  logic [SLOT_W-1:0]    hint_r, hint_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]     probe_r, probe_nxt;
  logic [OFFS_W-1:0]    prod_r, prod_nxt;
  res_t                 pend_r, pend_nxt;
  logic                 out_vld_r, out_vld_nxt;
  res_t                 out_r;
  logic                 load_out;

  logic [CNT_W-1:0]     hint_inc;
  logic [CNT_W-1:0]     idx_inc;
  logic [MUL_W-1:0]     mul;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  bsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign hint_inc = CNT_W'(hint_r) + CNT_W'(1);
  assign idx_inc  = CNT_W'(idx_r) + CNT_W'(1);
  assign mul      = MUL_W'(idx_r) * MUL_W'(buf_size);

  always_comb begin
    state_nxt = state_r;
    map_nxt   = map_r;
    hint_nxt  = hint_r;
    idx_nxt   = idx_r;
    probe_nxt = probe_r;
    prod_nxt  = prod_r;
    pend_nxt  = pend_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = q_head.offs;
    div_req.divisor  = buf_size;

    unique case (state_r)
      S_IDLE: begin
        if (q_vld) begin
          q_pop     = 1'b1;
          probe_nxt = '0;
          pend_nxt  = '{status: ST_OK, slot_index: '0, arena_offset: '0};
          if (q_head.op == OP_ALLOC) begin
            if (hint_inc < eff_n) begin
              idx_nxt   = IW'(hint_inc);
              state_nxt = S_SEARCH;
            end else begin
              // start slot is (hint + 1) mod count
              div_req.start    = 1'b1;
              div_req.dividend = OFFS_W'(hint_inc);
              div_req.divisor  = BSIZE_W'(eff_n);
              state_nxt        = S_MOD;
            end
          end else if (buf_size == '0) begin
            pend_nxt.status = ST_BAD_OFFSET;
            state_nxt       = S_DONE;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_MOD: begin
        if (div_rsp.done) begin
          idx_nxt   = IW'(div_rsp.rem);
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (!map_r[idx_r]) begin
          map_nxt[idx_r]      = 1'b1;
          hint_nxt            = SLOT_W'(idx_r);
          pend_nxt.slot_index = SLOT_W'(idx_r);
          prod_nxt            = mul[OFFS_W-1:0];
          state_nxt           = S_MUL;
        end else if (probe_r == eff_n - CNT_W'(1)) begin
          pend_nxt.status = ST_FULL;
          state_nxt       = S_DONE;
        end else begin
          probe_nxt = probe_r + CNT_W'(1);
          idx_nxt   = (idx_inc == eff_n) ? '0 : IW'(idx_inc);
        end
      end
      S_MUL: begin
        pend_nxt.arena_offset = OFFS_W'(CONTROL_AREA_BYTES) + prod_r;
        state_nxt             = S_DONE;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem != '0 || div_rsp.quot >= OFFS_W'(eff_n)) begin
            pend_nxt.status = ST_BAD_OFFSET;
            state_nxt       = S_DONE;
          end else begin
            idx_nxt   = IW'(div_rsp.quot);
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        pend_nxt.slot_index = SLOT_W'(idx_r);
        if (!map_r[idx_r]) begin
          pend_nxt.status = ST_NOT_ALLOCATED;
        end else begin
          map_nxt[idx_r] = 1'b0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the result word slot is free
        if (!out_vld_r || res_pop) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_pop && out_vld_r) begin
      out_vld_nxt = 1'b0;
    end
    if (load_out) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      map_r     <= '0;
      hint_r    <= SLOT_W'(MAX_SLOTS - 1);
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      map_r     <= map_nxt;
      hint_r    <= hint_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    probe_r <= probe_nxt;
    prod_r  <= prod_nxt;
    pend_r  <= pend_nxt;
    if (load_out) begin
      out_r <= pend_r;
    end
  end

  assign res_vld = out_vld_r;
  assign res     = out_r;

endmodule

FILE: src/bitmap_slot_allocator.sv
// Top level of the bitmap slot allocator: configuration registers, front
// queue and back end. Depends on bsa_pkg, bsa_front and bsa_back.
//
//   channel  | handshake      | payload
//   ---------+----------------+-------------------------------------------
//   input    | push / full    | in_command, in_buffer_offset
//   result   | pop / empty    | out_status, out_slot_index, out_arena_offset
//   config   | cfg_we         | cfg_index, cfg_wdata
//
// One word at a time in the back end; a two-deep front queue keeps taking
// commands meanwhile. Free runs the 32-step divider, then checks and clears
// the map bit (a bad offset skips the check, a zero buffer size the divider).
// Allocate probes slots from hint + 1 until one is free or all are taken,
// wrapping through the divider when the hint sits at or past the last slot.
// Reset (synchronous) clears the map, sets the hint to MAX_SLOTS - 1 and loads
// the register defaults. A full result word stalls the back end.
module bitmap_slot_allocator #(
  parameter int MAX_SLOTS          = 64,
  parameter int CONTROL_AREA_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_command,
  input  logic [31:0]                   in_buffer_offset,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    out_status,
  output logic [5:0]                    out_slot_index,
  output logic [31:0]                   out_arena_offset,
  input  logic                          cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsa_pkg::BSIZE_W-1:0]   cfg_wdata
);
  import bsa_pkg::*;

  logic [BSIZE_W-1:0] buf_size_r;
  logic [CNT_W-1:0]   slot_count_r;
  logic [CNT_W-1:0]   eff_n;
  logic               q_vld;
  logic               q_pop;
  req_t               q_head;
  logic               res_vld;
  res_t               res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r   <= BSIZE_RST;
      slot_count_r <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUF_SIZE:   buf_size_r   <= cfg_wdata;
        CFG_SLOT_COUNT: slot_count_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the slot count to 1..MAX_SLOTS
  always_comb begin
    if (slot_count_r == '0) begin
      eff_n = CNT_W'(1);
    end else if (slot_count_r > CNT_W'(MAX_SLOTS)) begin
      eff_n = CNT_W'(MAX_SLOTS);
    end else begin
      eff_n = slot_count_r;
    end
  end

  bsa_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_command       (in_command),
    .in_buffer_offset (in_buffer_offset),
    .q_vld            (q_vld),
    .q_head           (q_head),
    .q_pop            (q_pop)
  );

  bsa_back #(
    .MAX_SLOTS          (MAX_SLOTS),
    .CONTROL_AREA_BYTES (CONTROL_AREA_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_vld    (q_vld),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .buf_size (buf_size_r),
    .eff_n    (eff_n),
    .res_vld  (res_vld),
    .res      (res),
    .res_pop  (pop)
  );

  assign empty            = !res_vld;
  assign out_status       = res.status;
  assign out_slot_index   = res.slot_index;
  assign out_arena_offset = res.arena_offset;

endmodule
